// ===== rtl/lcdw_pkg.sv =====
`default_nettype none

package lcdw_pkg;

    // fixed power-on timing in ticks
    localparam logic [15:0] POWER_ON_TICKS    = 16'd15000;
    localparam logic [15:0] SECOND_WAIT_TICKS = 16'd5000;
    localparam logic [15:0] THIRD_WAIT_TICKS  = 16'd100;

    // command bytes
    localparam logic [7:0] CMD_FUNC_SET = 8'h38;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;
    localparam logic [7:0] CMD_DDRAM    = 8'h80;

    // power-on sequence steps
    localparam logic [3:0] INIT_POWER_WAIT  = 4'd0;
    localparam logic [3:0] INIT_FSET_1      = 4'd1;
    localparam logic [3:0] INIT_SECOND_WAIT = 4'd2;
    localparam logic [3:0] INIT_FSET_2      = 4'd3;
    localparam logic [3:0] INIT_THIRD_WAIT  = 4'd4;
    localparam logic [3:0] INIT_FSET_3      = 4'd5;
    localparam logic [3:0] INIT_FSET_4      = 4'd6;
    localparam logic [3:0] INIT_ENTRY       = 4'd7;
    localparam logic [3:0] INIT_DISPLAY     = 4'd8;
    localparam logic [3:0] INIT_CLEAR       = 4'd9;
    localparam logic [3:0] INIT_HOME_POS    = 4'd10;
    localparam logic [3:0] INIT_DONE        = 4'd11;

    // configuration reset values
    localparam logic [7:0]  PHASE_TICKS_RST   = 8'd40;
    localparam logic [15:0] CLEAR_WAIT_RST    = 16'd2000;
    localparam logic [7:0]  ENTRY_MODE_RST    = 8'h06;
    localparam logic [7:0]  DISPLAY_CTRL_RST  = 8'h0E;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_CMD  = 2'd1,
        REQ_DATA = 2'd2,
        REQ_POS  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CFG_PHASE_TICKS  = 2'd0,
        CFG_CLEAR_WAIT   = 2'd1,
        CFG_ENTRY_MODE   = 2'd2,
        CFG_DISPLAY_CTRL = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        TAIL_NONE  = 2'd0,
        TAIL_PHASE = 2'd1,
        TAIL_CLEAR = 2'd2
    } tail_t;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_WAIT  = 6'b000010,
        PH_SETUP = 6'b000100,
        PH_HIGH  = 6'b001000,
        PH_HOLD  = 6'b010000,
        PH_TAIL  = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] value;
        logic       row;
        logic [5:0] column;
    } item_t;

    typedef struct packed {
        logic        rs_line;
        logic        rw_line;
        logic        enable_line;
        logic [7:0]  data_bus;
        logic        busy_res;
        logic        rejected;
    } res_t;

    typedef struct packed {
        logic [7:0]  phase_ticks;
        logic [15:0] clear_wait_ticks;
        logic [7:0]  entry_mode;
        logic [7:0]  display_control;
    } cfg_t;

    // clear and home need the long tail
    function automatic tail_t cmd_tail(input logic [7:0] b);
        tail_t t;
        t = TAIL_NONE;
        if (b == CMD_CLEAR || b == CMD_HOME) begin
            t = TAIL_CLEAR;
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lcdw_core.sv =====
`default_nettype none

module lcdw_core
    import lcdw_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  step_en,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output res_t       res
);

    phase_t      phase_reg, phase_next;
    logic [15:0] wait_reg, wait_next;
    logic [3:0]  step_reg, step_next;
    logic [7:0]  byte_reg, byte_next;
    logic        rs_reg, rs_next;
    tail_t       tail_reg, tail_next;
    logic        en_reg, en_next;
    logic        rej;

    logic [7:0]  one_phase;
    logic [15:0] wait_dec;

    phase_t      fin_phase;
    logic [15:0] fin_wait;
    logic [3:0]  fin_step;
    logic [7:0]  fin_byte;
    logic        fin_rs;
    tail_t       fin_tail;
    logic [7:0]  init_byte;
    logic        init_write;
    logic [7:0]  pos_byte;

    // zero phase length counts as one tick
    assign one_phase = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;
    assign wait_dec  = (wait_reg != 16'd0) ? (wait_reg - 16'd1) : 16'd0;
    assign pos_byte  = CMD_DDRAM | {1'b0, item.row, 6'b000000} | {2'b00, item.column};

    // end of the current write or wait: start the next power-on step, or go idle once the sequence is done
    always_comb begin
        fin_phase  = PH_IDLE;
        fin_wait   = 16'd0;
        fin_step   = step_reg;
        fin_byte   = byte_reg;
        fin_rs     = rs_reg;
        fin_tail   = tail_reg;
        init_byte  = CMD_FUNC_SET;
        init_write = 1'b0;
        if (step_reg < INIT_DONE) begin
            fin_step = step_reg + 4'd1;
            case (fin_step) inside
                INIT_SECOND_WAIT: begin
                    fin_phase = PH_WAIT;
                    fin_wait  = SECOND_WAIT_TICKS;
                end
                INIT_THIRD_WAIT: begin
                    fin_phase = PH_WAIT;
                    fin_wait  = THIRD_WAIT_TICKS;
                end
                INIT_FSET_1, INIT_FSET_2, INIT_FSET_3, INIT_FSET_4: begin
                    init_write = 1'b1;
                    init_byte  = CMD_FUNC_SET;
                end
                INIT_ENTRY: begin
                    init_write = 1'b1;
                    init_byte  = cfg.entry_mode;
                end
                INIT_DISPLAY: begin
                    init_write = 1'b1;
                    init_byte  = cfg.display_control;
                end
                INIT_CLEAR: begin
                    init_write = 1'b1;
                    init_byte  = CMD_CLEAR;
                end
                INIT_HOME_POS: begin
                    init_write = 1'b1;
                    init_byte  = CMD_DDRAM;
                end
                default: begin
                    fin_step = INIT_DONE;
                end
            endcase
        end
        if (init_write) begin
            fin_phase = PH_SETUP;
            fin_wait  = {8'h00, one_phase};
            fin_rs    = 1'b0;
            fin_byte  = init_byte;
            fin_tail  = cmd_tail(init_byte);
        end
    end

    // per-item sequencer update
    always_comb begin
        phase_next = phase_reg;
        wait_next  = wait_reg;
        step_next  = step_reg;
        byte_next  = byte_reg;
        rs_next    = rs_reg;
        tail_next  = tail_reg;
        en_next    = en_reg;
        rej        = 1'b0;
        if (item.req_type == REQ_TICK) begin
            if (phase_reg != PH_IDLE) begin
                wait_next = wait_dec;
                if (wait_dec == 16'd0) begin
                    unique case (phase_reg)
                        PH_SETUP: begin
                            phase_next = PH_HIGH;
                            en_next    = 1'b1;
                            wait_next  = {8'h00, one_phase};
                        end
                        PH_HIGH: begin
                            phase_next = PH_HOLD;
                            en_next    = 1'b0;
                            wait_next  = {7'b0000000, one_phase, 1'b0};
                        end
                        PH_HOLD: begin
                            if (tail_reg == TAIL_PHASE) begin
                                phase_next = PH_TAIL;
                                wait_next  = {8'h00, one_phase};
                            end else if (tail_reg == TAIL_CLEAR &&
                                         cfg.clear_wait_ticks != 16'd0) begin
                                phase_next = PH_TAIL;
                                wait_next  = cfg.clear_wait_ticks;
                            end else begin
                                phase_next = fin_phase;
                                wait_next  = fin_wait;
                                step_next  = fin_step;
                                byte_next  = fin_byte;
                                rs_next    = fin_rs;
                                tail_next  = fin_tail;
                                en_next    = 1'b0;
                            end
                        end
                        default: begin
                            phase_next = fin_phase;
                            wait_next  = fin_wait;
                            step_next  = fin_step;
                            byte_next  = fin_byte;
                            rs_next    = fin_rs;
                            tail_next  = fin_tail;
                            en_next    = 1'b0;
                        end
                    endcase
                end
            end
        end else if (phase_reg != PH_IDLE) begin
            rej = 1'b1;
        end else begin
            phase_next = PH_SETUP;
            wait_next  = {8'h00, one_phase};
            en_next    = 1'b0;
            case (item.req_type)
                REQ_CMD: begin
                    rs_next   = 1'b0;
                    byte_next = item.value;
                    tail_next = cmd_tail(item.value);
                end
                REQ_DATA: begin
                    rs_next   = 1'b1;
                    byte_next = item.value;
                    tail_next = TAIL_PHASE;
                end
                default: begin
                    rs_next   = 1'b0;
                    byte_next = pos_byte;
                    tail_next = TAIL_PHASE;
                end
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WAIT;
            wait_reg  <= POWER_ON_TICKS;
            step_reg  <= INIT_POWER_WAIT;
            byte_reg  <= 8'h00;
            rs_reg    <= 1'b0;
            tail_reg  <= TAIL_NONE;
            en_reg    <= 1'b0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            wait_reg  <= wait_next;
            step_reg  <= step_next;
            byte_reg  <= byte_next;
            rs_reg    <= rs_next;
            tail_reg  <= tail_next;
            en_reg    <= en_next;
        end
    end

    // result reflects the state after this item
    always_comb begin
        res.rs_line     = rs_next;
        res.rw_line     = 1'b0;
        res.enable_line = en_next;
        res.data_bus    = byte_next;
        res.busy_res    = (phase_next != PH_IDLE);
        res.rejected    = rej;
    end

endmodule

`default_nettype wire

// ===== rtl/char_lcd_write_controller_unit.sv =====
// an item is held in the input register, then its result in the result register
// throughput: one item per cycle while m_tready is high, set by the register pair
// the output side stalls the input only once both registers hold an item
// reset (synchronous, aresetn low): valid flags and configuration registers are
// reset and the sequencer restarts the power-on sequence from its first wait
`default_nettype none

module char_lcd_write_controller_unit
    import lcdw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // value[7:0], row[8], column[14:9], zero
    input  wire logic [1:0]  s_tuser,   // req_type[1:0]
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // rs_line, rw_line, enable_line, data_bus,
                                        // busy_res, rejected, zero
    // configuration writes
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    cfg_t  cfg_reg;
    item_t in_item_reg;
    logic  in_valid_reg;
    res_t  out_res_reg;
    logic  out_valid_reg;
    res_t  core_res;
    item_t s_item;
    logic  adv;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.phase_ticks      <= PHASE_TICKS_RST;
            cfg_reg.clear_wait_ticks <= CLEAR_WAIT_RST;
            cfg_reg.entry_mode       <= ENTRY_MODE_RST;
            cfg_reg.display_control  <= DISPLAY_CTRL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PHASE_TICKS:  cfg_reg.phase_ticks      <= cfg_wdata[7:0];
                CFG_CLEAR_WAIT:   cfg_reg.clear_wait_ticks <= cfg_wdata;
                CFG_ENTRY_MODE:   cfg_reg.entry_mode       <= cfg_wdata[7:0];
                CFG_DISPLAY_CTRL: cfg_reg.display_control  <= cfg_wdata[7:0];
                default:          cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // unpack the input item
    always_comb begin
        s_item.req_type = s_tuser;
        s_item.value    = s_tdata[7:0];
        s_item.row      = s_tdata[8];
        s_item.column   = s_tdata[14:9];
    end

    // an item moves into the result register when that has room
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= s_item;
        end
    end

    lcdw_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (adv),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .res     (core_res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_res_reg.rejected,
                       out_res_reg.busy_res,
                       out_res_reg.data_bus,
                       out_res_reg.enable_line,
                       out_res_reg.rw_line,
                       out_res_reg.rs_line};

    // a dropped request leaves the sequencer busy
    a_rej_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_res_reg.rejected |-> out_res_reg.busy_res)
        else $error("rejected result while not busy");

    // the strobe is high only inside a write sequence
    a_en_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_res_reg.enable_line |-> out_res_reg.busy_res)
        else $error("enable high while idle");

    // an item handed to the core shows up as a result
    a_adv_out: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> out_valid_reg)
        else $error("advanced item lost");

    // a held input item keeps its contents while the result side stalls
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !adv |=> in_valid_reg && $stable(in_item_reg))
        else $error("held item changed");

endmodule

`default_nettype wire
